// File: sv/mlr_pkg.sv
package mlr_pkg;

  // Coordinate width of the pixel grid
  localparam int COORD_BITS = 12;
  // Decision value and increments stay within +-2^(COORD_BITS+1)
  localparam int DEC_BITS   = COORD_BITS + 4;

  // Transaction kinds on the input channel
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Line case from slope and direction of dy
  typedef enum logic [1:0] {
    OCT_SHALLOW_UP = 2'd0,
    OCT_SHALLOW_DN = 2'd1,
    OCT_STEEP_UP   = 2'd2,
    OCT_STEEP_DN   = 2'd3
  } oct_t;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  typedef struct packed {
    logic   kind;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_item_t;

endpackage

// File: sv/midpoint_line_rasterizer.sv
// Midpoint line rasterizer.
// Input channel (in_valid/in_ready/in_data): a start transaction carries two
// endpoints and answers the first pixel of the line; each tick transaction
// then answers the next pixel. A tick while no line is active is taken and
// answers nothing. A start while a line is active abandons that line.
// Output channel (out_valid/out_ready/out_data): one pixel per answered
// transaction, with last_pixel set on the final endpoint.
// Timing: a pixel appears on out_data in the cycle after its transaction is
// taken. Throughput: one transaction per cycle while not stalled; the
// per-pixel step is one add on the decision value and one coordinate
// compare, done between the line state registers and the output register.
// Stall: the output register holds its pixel while out_ready is low;
// in_ready then drops, and rises again in the cycle the pixel is taken, so
// a new transaction enters in the same cycle the old pixel leaves.
// Reset (rst_n low at a clock edge): the block goes idle with the output
// register empty.
module midpoint_line_rasterizer
  import mlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int EXT_BITS = DEC_BITS - COORD_BITS;

  // Line state
  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  coord_t stop_r, stop_nxt;
  dec_t   decision_r, decision_nxt;
  dec_t   inc_keep_r, inc_keep_nxt;
  dec_t   inc_move_r, inc_move_nxt;
  oct_t   oct_r, oct_nxt;
  logic   busy_r, busy_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic   in_fire;
  logic   emit_c;
  logic   last_c;

  // Start set-up
  logic   swap_c;
  coord_t xa_c, ya_c, xb_c, yb_c;
  dec_t   dx_c, dy_c, ady_c, dx2_c, dy2_c;
  logic   shallow_c, dy_pos_c;

  // Tick step
  logic   move_c;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Order the endpoints and form the deltas
  always_comb begin
    swap_c    = in_data.x_start > in_data.x_end;
    xa_c      = swap_c ? in_data.x_end   : in_data.x_start;
    ya_c      = swap_c ? in_data.y_end   : in_data.y_start;
    xb_c      = swap_c ? in_data.x_start : in_data.x_end;
    yb_c      = swap_c ? in_data.y_start : in_data.y_end;
    dx_c      = $signed({{EXT_BITS{1'b0}}, xb_c}) - $signed({{EXT_BITS{1'b0}}, xa_c});
    dy_c      = $signed({{EXT_BITS{1'b0}}, yb_c}) - $signed({{EXT_BITS{1'b0}}, ya_c});
    ady_c     = dy_c[DEC_BITS-1] ? -dy_c : dy_c;
    dx2_c     = {dx_c[DEC_BITS-2:0], 1'b0};
    dy2_c     = {dy_c[DEC_BITS-2:0], 1'b0};
    shallow_c = dx_c >= ady_c;
    dy_pos_c  = !dy_c[DEC_BITS-1] && (dy_c != '0);
  end

  // Pick the minor-axis step from the decision sign
  always_comb begin
    case (oct_r) inside
      OCT_SHALLOW_DN, OCT_STEEP_UP: move_c = !decision_r[DEC_BITS-1];
      default:                      move_c = decision_r[DEC_BITS-1];
    endcase
  end

  // Next line state and next pixel
  always_comb begin
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    stop_nxt     = stop_r;
    decision_nxt = decision_r;
    inc_keep_nxt = inc_keep_r;
    inc_move_nxt = inc_move_r;
    oct_nxt      = oct_r;
    busy_nxt     = busy_r;
    emit_c       = 1'b0;
    last_c       = 1'b0;

    if (in_fire && in_data.kind == KIND_START) begin
      // Load a new line
      emit_c    = 1'b1;
      cur_x_nxt = xa_c;
      cur_y_nxt = ya_c;
      if (shallow_c) begin
        stop_nxt = xb_c;
        last_c   = xa_c == xb_c;
        if (dy_pos_c) begin
          oct_nxt      = OCT_SHALLOW_UP;
          decision_nxt = dx_c - dy2_c;
          inc_keep_nxt = -dy2_c;
          inc_move_nxt = dx2_c - dy2_c;
        end else begin
          oct_nxt      = OCT_SHALLOW_DN;
          decision_nxt = -dx_c - dy2_c;
          inc_keep_nxt = -dy2_c;
          inc_move_nxt = -dx2_c - dy2_c;
        end
      end else begin
        stop_nxt = yb_c;
        last_c   = ya_c == yb_c;
        if (dy_pos_c) begin
          oct_nxt      = OCT_STEEP_UP;
          decision_nxt = dx2_c - dy_c;
          inc_keep_nxt = dx2_c;
          inc_move_nxt = dx2_c - dy2_c;
        end else begin
          oct_nxt      = OCT_STEEP_DN;
          decision_nxt = -dx2_c - dy_c;
          inc_keep_nxt = -dx2_c;
          inc_move_nxt = -dx2_c - dy2_c;
        end
      end
      busy_nxt = !last_c;
    end else if (in_fire && busy_r) begin
      // Advance one pixel along the major axis
      emit_c       = 1'b1;
      decision_nxt = decision_r + (move_c ? inc_move_r : inc_keep_r);
      case (oct_r)
        OCT_SHALLOW_UP: begin
          cur_x_nxt = cur_x_r + 1'b1;
          cur_y_nxt = move_c ? cur_y_r + 1'b1 : cur_y_r;
        end
        OCT_SHALLOW_DN: begin
          cur_x_nxt = cur_x_r + 1'b1;
          cur_y_nxt = move_c ? cur_y_r - 1'b1 : cur_y_r;
        end
        OCT_STEEP_UP: begin
          cur_y_nxt = cur_y_r + 1'b1;
          cur_x_nxt = move_c ? cur_x_r + 1'b1 : cur_x_r;
        end
        default: begin
          cur_y_nxt = cur_y_r - 1'b1;
          cur_x_nxt = move_c ? cur_x_r + 1'b1 : cur_x_r;
        end
      endcase
      if (oct_r == OCT_SHALLOW_UP || oct_r == OCT_SHALLOW_DN) begin
        last_c = cur_x_nxt == stop_r;
      end else begin
        last_c = cur_y_nxt == stop_r;
      end
      busy_nxt = !last_c;
    end
  end

  // Fill or drain the output register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (emit_c) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.pixel_x    = cur_x_nxt;
      out_data_nxt.pixel_y    = cur_y_nxt;
      out_data_nxt.last_pixel = last_c;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    stop_r     <= stop_nxt;
    decision_r <= decision_nxt;
    inc_keep_r <= inc_keep_nxt;
    inc_move_r <= inc_move_nxt;
    oct_r      <= oct_nxt;
    out_data_r <= out_data_nxt;
  end

  // A start transaction always answers a pixel
  a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.kind == KIND_START |=> out_valid_r)
    else $error("start transaction gave no pixel");

  // A tick with no active line answers nothing
  a_idle_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.kind == KIND_TICK && !busy_r |=> !out_valid_r)
    else $error("idle tick gave a pixel");

  // The final pixel ends the line
  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    emit_c && last_c |=> !busy_r)
    else $error("line still active after last pixel");

  // An active line has not yet reached its stop coordinate
  a_busy_not_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((oct_r == OCT_SHALLOW_UP || oct_r == OCT_SHALLOW_DN) ?
                (cur_x_r != stop_r) : (cur_y_r != stop_r)))
    else $error("active line already at its end");

endmodule

// File: bench/tb_top.sv
module tb_top
  import mlr_pkg::*;
();

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int MAX_GAP   = 6;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Line state of the predictor
  coord_t line_x;
  coord_t line_y;
  coord_t line_stop;
  dec_t   line_dec;
  dec_t   line_keep_inc;
  dec_t   line_move_inc;
  oct_t   line_case;
  logic   line_active;

  out_item_t pixel_q[$];
  int        err_count;
  int        items_sent;
  int        in_gap_max;
  int        out_gap_max;
  int        out_wait;

  midpoint_line_rasterizer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Work out the pixel that one transaction yields, if any, and advance the line
  function automatic logic next_pixel(input in_item_t it, output out_item_t px);
    coord_t xa, ya, xb, yb, tmp;
    int     dx, dy, ady;
    logic   move, done;
    px = '0;
    if (it.kind == KIND_START) begin
      xa = it.x_start;
      ya = it.y_start;
      xb = it.x_end;
      yb = it.y_end;
      if (xa > xb) begin
        tmp = xa; xa = xb; xb = tmp;
        tmp = ya; ya = yb; yb = tmp;
      end
      dx = int'(xb) - int'(xa);
      dy = int'(yb) - int'(ya);
      ady = (dy < 0) ? -dy : dy;
      line_x = xa;
      line_y = ya;
      if (dx >= ady) begin
        line_stop = xb;
        if (dy > 0) begin
          line_case     = OCT_SHALLOW_UP;
          line_dec      = dec_t'(dx - 2 * dy);
          line_keep_inc = dec_t'(-2 * dy);
          line_move_inc = dec_t'(2 * (dx - dy));
        end else begin
          line_case     = OCT_SHALLOW_DN;
          line_dec      = dec_t'(-dx - 2 * dy);
          line_keep_inc = dec_t'(-2 * dy);
          line_move_inc = dec_t'(-2 * (dx + dy));
        end
      end else begin
        line_stop = yb;
        if (dy > 0) begin
          line_case     = OCT_STEEP_UP;
          line_dec      = dec_t'(2 * dx - dy);
          line_keep_inc = dec_t'(2 * dx);
          line_move_inc = dec_t'(2 * (dx - dy));
        end else begin
          line_case     = OCT_STEEP_DN;
          line_dec      = dec_t'(-2 * dx - dy);
          line_keep_inc = dec_t'(-2 * dx);
          line_move_inc = dec_t'(-2 * (dx + dy));
        end
      end
    end else begin
      // Tick with no line in progress: nothing happens
      if (!line_active) return 1'b0;
      if (line_case == OCT_SHALLOW_DN || line_case == OCT_STEEP_UP)
        move = (line_dec >= 0);
      else
        move = (line_dec < 0);
      line_dec = line_dec + (move ? line_move_inc : line_keep_inc);
      case (line_case)
        OCT_SHALLOW_UP: begin
          if (move) line_y = line_y + 1'b1;
          line_x = line_x + 1'b1;
        end
        OCT_SHALLOW_DN: begin
          if (move) line_y = line_y - 1'b1;
          line_x = line_x + 1'b1;
        end
        OCT_STEEP_UP: begin
          if (move) line_x = line_x + 1'b1;
          line_y = line_y + 1'b1;
        end
        default: begin
          if (move) line_x = line_x + 1'b1;
          line_y = line_y - 1'b1;
        end
      endcase
    end
    if (line_case == OCT_SHALLOW_UP || line_case == OCT_SHALLOW_DN)
      done = (line_x == line_stop);
    else
      done = (line_y == line_stop);
    line_active   = !done;
    px.pixel_x    = line_x;
    px.pixel_y    = line_y;
    px.last_pixel = done;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 100) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Check each taken pixel against the oldest prediction, then predict the new transaction
  always @(posedge clk) begin : pixel_check
    out_item_t want;
    out_item_t got;
    out_item_t px;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                    got.pixel_x, got.pixel_y, got.last_pixel));
        end else begin
          want = pixel_q.pop_front();
          if (got.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("pixel_x %0d, expected %0d", got.pixel_x, want.pixel_x));
          if (got.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("pixel_y %0d, expected %0d", got.pixel_y, want.pixel_y));
          if (got.last_pixel !== want.last_pixel)
            report_mismatch($sformatf("last_pixel %0b, expected %0b at (%0d,%0d)",
                                      got.last_pixel, want.last_pixel,
                                      want.pixel_x, want.pixel_y));
        end
        out_wait = $urandom_range(0, out_gap_max);
      end
      if (in_valid && in_ready) begin
        if (next_pixel(in_data, px)) pixel_q.push_back(px);
      end
    end
  end

  // Hold ready low after each taken pixel while the drawn wait counts down
  always @(negedge clk) begin
    if (out_wait > 0) begin
      out_ready <= 1'b0;
      out_wait  <= out_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Send one transaction; entered and left at a falling edge
  task automatic send_item(input in_item_t it);
    int gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Tick with random payload, which the block ignores
  task automatic send_tick();
    in_item_t it;
    it      = in_item_t'(49'({$urandom(), $urandom()}));
    it.kind = KIND_TICK;
    send_item(it);
  endtask

  task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                           input int ticks);
    in_item_t it;
    it.kind    = KIND_START;
    it.x_start = coord_t'(x0);
    it.y_start = coord_t'(y0);
    it.x_end   = coord_t'(x1);
    it.y_end   = coord_t'(y1);
    send_item(it);
    repeat (ticks) send_tick();
  endtask

  // Draw a random line within span of a random first endpoint; finish, overrun or abandon it
  task automatic random_line(input int span, input int abandon_max);
    int x0, y0, x1, y1, len, pick, ticks;
    x0 = $urandom_range(0, COORD_MAX);
    y0 = $urandom_range(0, COORD_MAX);
    x1 = $urandom_range((x0 > span) ? x0 - span : 0,
                        (x0 + span < COORD_MAX) ? x0 + span : COORD_MAX);
    y1 = $urandom_range((y0 > span) ? y0 - span : 0,
                        (y0 + span < COORD_MAX) ? y0 + span : COORD_MAX);
    len = (x1 > x0) ? x1 - x0 : x0 - x1;
    if (((y1 > y0) ? y1 - y0 : y0 - y1) > len) len = (y1 > y0) ? y1 - y0 : y0 - y1;
    pick = $urandom_range(0, 99);
    if (abandon_max > 0)
      ticks = $urandom_range(0, (len < abandon_max) ? len : abandon_max);
    else if (pick < 80)
      ticks = len;
    else if (pick < 90)
      ticks = len + $urandom_range(1, 3);
    else
      ticks = $urandom_range(0, len);
    draw_line(x0, y0, x1, y1, ticks);
  endtask

  task automatic test_corner_lines();
    in_gap_max  = MAX_GAP;
    out_gap_max = MAX_GAP;
    send_tick();                           // idle after reset
    draw_line(5, 5, 5, 5, 1);              // single point, then idle tick
    draw_line(10, 20, 12, 20, 2);          // horizontal
    draw_line(0, 0, 2, 1, 2);              // shallow rising
    draw_line(20, 0, 17, 2, 3);            // swapped, shallow falling
    draw_line(7, 7, 8, 10, 3);             // steep rising
    draw_line(9, 2, 9, 0, 2);              // vertical falling
    draw_line(0, 0, COORD_MAX, COORD_MAX, 2);           // abandoned by next start
    draw_line(COORD_MAX, 0, 0, COORD_MAX, 1);           // abandoned by next start
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
  endtask

  task automatic test_random_lines();
    int mode;
    while (items_sent < 750) begin
      // Change idling every few lines, sometimes none at all
      mode = $urandom_range(0, 3);
      in_gap_max  = (mode == 0) ? 0 : MAX_GAP;
      out_gap_max = (mode == 0 || mode == 1) ? 0 : MAX_GAP;
      repeat (4) begin
        if ($urandom_range(0, 19) == 0) send_tick();
        else random_line($urandom_range(0, 24), 0);
      end
    end
  endtask

  task automatic test_abandoned_lines();
    in_gap_max  = MAX_GAP;
    out_gap_max = MAX_GAP;
    repeat (8) random_line(COORD_MAX, 40);
  endtask

  task automatic test_back_to_back();
    in_gap_max  = 0;
    out_gap_max = 0;
    while (items_sent < 1050) random_line($urandom_range(0, 12), 0);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    out_wait    = 0;
    err_count   = 0;
    items_sent  = 0;
    in_gap_max  = 0;
    out_gap_max = 0;
    line_x        = '0;
    line_y        = '0;
    line_stop     = '0;
    line_dec      = '0;
    line_keep_inc = '0;
    line_move_inc = '0;
    line_case     = OCT_SHALLOW_UP;
    line_active   = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corner_lines();
    test_random_lines();
    test_abandoned_lines();
    test_back_to_back();

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && pixel_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
